### rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// No dependencies; imported by the controller, the datapath and the top level.
package tcw_pkg;

    // Action codes carried in the input word
    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Character codes
    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;

    // Reset value of the default attribute register
    localparam logic [7:0] DEF_ATTR_RESET = 8'd7;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;      // latch the accepted input word
        logic exec_put;     // write the cell and move the cursor
        logic rd_cell;      // read the target cell
        logic walk_scroll;  // start a scroll pass over the buffer
        logic walk_blank;   // start a blank-fill pass over the buffer
        logic cur_clear;    // home the cursor
        logic load_out;     // load the result register
    } tcw_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_put;
        logic is_read;
        logic is_clear;
        logic oor;          // target column or row out of range
        logic need_scroll;  // the put moves the cursor past the last row
        logic walk_busy;    // a buffer pass is still running
    } tcw_sts_t;

endpackage

### rtl/tcw_ctrl.sv
// Controller state machine for the text console writer.
// Depends on tcw_pkg; drives tcw_cmd_t commands and reads tcw_sts_t status.
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  tcw_sts_t sts,
    output tcw_cmd_t cmd
);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_RDWAIT = 3'd3;
    localparam logic [2:0] ST_WALK   = 3'd4;
    localparam logic [2:0] ST_RESULT = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign in_ready  = (state_reg == ST_IDLE);

    // Sequence one word at a time
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                if (!sts.walk_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                priority if (sts.is_clear)
                begin
                    cmd.walk_blank = 1'b1;
                    cmd.cur_clear  = 1'b1;
                    state_next     = ST_WALK;
                end
                else if (sts.is_read && !sts.oor)
                begin
                    cmd.rd_cell = 1'b1;
                    state_next  = ST_RDWAIT;
                end
                else if (sts.is_put && !sts.oor && sts.need_scroll)
                begin
                    cmd.exec_put    = 1'b1;
                    cmd.walk_scroll = 1'b1;
                    state_next      = ST_WALK;
                end
                else
                begin
                    cmd.exec_put = sts.is_put && !sts.oor;
                    if (out_free)
                    begin
                        cmd.load_out = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_RDWAIT:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_WALK:
            begin
                if (!sts.walk_busy)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // Hold the result valid until the sink takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/tcw_datapath.sv
// Datapath for the text console writer: cell buffer, cursor, buffer pass
// sequencer and result register. Depends on tcw_pkg.
module tcw_datapath
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  tcw_cmd_t          cmd,
    output tcw_sts_t          sts,
    input  logic              cfg_write_en,
    input  logic [7:0]        cfg_write_data,
    input  logic [1:0]        action,
    input  logic [7:0]        char_code,
    input  logic [7:0]        attribute,
    input  logic signed [8:0] column,
    input  logic signed [8:0] line,
    output logic              status,
    output logic [10:0]       cursor_position,
    output logic [7:0]        cell_char,
    output logic [7:0]        cell_attr
);

    localparam int CELLS      = COLUMNS * ROWS;
    localparam int AW         = $clog2(CELLS);
    localparam int CW         = $clog2(CELLS + 1);
    localparam int RW         = $clog2(ROWS + 1);
    localparam int CLW        = $clog2(COLUMNS + 1);
    localparam int LAST_START = CELLS - COLUMNS;

    // Cell buffer and its registered read port
    logic [15:0] mem [CELLS];
    logic        mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [15:0] mem_wdata;
    logic [15:0] rdata_reg;

    // Captured input word
    logic [1:0]        act_reg;
    logic [7:0]        ch_reg, attr_reg;
    logic signed [8:0] col_reg, row_reg;

    // Configuration and cursor
    logic [7:0]     def_attr_reg;
    logic [AW-1:0]  cur_cell_reg, cur_cell_next;
    logic [RW-1:0]  cur_row_reg, cur_row_next;
    logic [CLW-1:0] cur_col_reg, cur_col_next;

    // Buffer pass sequencer
    logic          walk_act_reg, walk_scroll_reg, walk_blank_reg;
    logic [AW-1:0] walk_idx_reg;
    logic          wr_pend_reg;
    logic [AW-1:0] wr_idx_reg;

    // Target resolution
    logic           explicit_tgt, is_newline;
    logic [RW-1:0]  t_row, n_row;
    logic [CLW-1:0] t_col, n_col;
    logic [CW-1:0]  t_pos, n_pos;
    logic [7:0]     attr_eff;
    logic [15:0]    fill_word, walk_word;
    logic [15:0]    cur_wide;

    // Decode the captured word
    assign sts.is_put   = (act_reg == ACT_PUT);
    assign sts.is_read  = (act_reg == ACT_READ);
    assign sts.is_clear = (act_reg == ACT_CLEAR);
    assign sts.oor      = (!col_reg[8] && ({1'b0, col_reg[7:0]} >= 9'(COLUMNS)))
                       || (!row_reg[8] && ({1'b0, row_reg[7:0]} >= 9'(ROWS)));
    assign sts.walk_busy = walk_act_reg || wr_pend_reg;

    assign explicit_tgt = !col_reg[8] && !row_reg[8];
    assign is_newline   = (ch_reg == NEWLINE_CODE);
    assign attr_eff     = (attr_reg == 8'd0) ? def_attr_reg : attr_reg;

    // Pick the target cell: explicit coordinates or the cursor
    always_comb
    begin
        if (explicit_tgt)
        begin
            t_row = RW'(row_reg[7:0]);
            t_col = CLW'(col_reg[7:0]);
            t_pos = CW'(t_row) * CW'(COLUMNS) + CW'(t_col);
        end
        else
        begin
            t_row = cur_row_reg;
            t_col = cur_col_reg;
            t_pos = CW'(cur_cell_reg);
        end
    end

    // Advance past the target: next cell or start of next row
    always_comb
    begin
        if (is_newline)
        begin
            n_row = t_row + RW'(1);
            n_col = '0;
            n_pos = t_pos - CW'(t_col) + CW'(COLUMNS);
        end
        else if ({1'b0, t_col} + (CLW + 1)'(1) == (CLW + 1)'(COLUMNS))
        begin
            n_row = t_row + RW'(1);
            n_col = '0;
            n_pos = t_pos + CW'(1);
        end
        else
        begin
            n_row = t_row;
            n_col = t_col + CLW'(1);
            n_pos = t_pos + CW'(1);
        end
    end

    assign sts.need_scroll = ({1'b0, n_row} == (RW + 1)'(ROWS));

    // Home the cursor on clear, or move it after a put, pulling back one row after a scroll
    always_comb
    begin
        cur_cell_next = cur_cell_reg;
        cur_row_next  = cur_row_reg;
        cur_col_next  = cur_col_reg;
        if (cmd.cur_clear)
        begin
            cur_cell_next = '0;
            cur_row_next  = '0;
            cur_col_next  = '0;
        end
        else if (cmd.exec_put)
        begin
            cur_col_next = n_col;
            if (sts.need_scroll)
            begin
                cur_row_next  = RW'(ROWS - 1);
                cur_cell_next = AW'(n_pos - CW'(COLUMNS));
            end
            else
            begin
                cur_row_next  = n_row;
                cur_cell_next = AW'(n_pos);
            end
        end
    end

    // Fill word and the word written by the pass
    assign fill_word = walk_blank_reg ? {def_attr_reg, SPACE_CODE} : 16'd0;
    always_comb
    begin
        if (walk_scroll_reg)
        begin
            walk_word = (CW'(wr_idx_reg) >= CW'(LAST_START)) ? 16'd0 : rdata_reg;
        end
        else
        begin
            walk_word = fill_word;
        end
    end

    // Steer the memory ports
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wr_idx_reg;
        mem_wdata = walk_word;
        mem_re    = 1'b0;
        mem_raddr = AW'(t_pos);
        if (wr_pend_reg)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.exec_put && !is_newline)
        begin
            mem_we    = 1'b1;
            mem_waddr = AW'(t_pos);
            mem_wdata = {attr_eff, ch_reg};
        end
        if (walk_act_reg)
        begin
            mem_raddr = AW'(CW'(walk_idx_reg) + CW'(COLUMNS));
            mem_re    = walk_scroll_reg && (CW'(walk_idx_reg) < CW'(LAST_START));
        end
        else if (cmd.rd_cell)
        begin
            mem_re = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // Latch the input word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg  <= action;
            ch_reg   <= char_code;
            attr_reg <= attribute;
            col_reg  <= column;
            row_reg  <= line;
        end
    end

    // Walk the buffer one cell a cycle; the write index and its enable are the read index and walk flag, registered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_act_reg    <= 1'b1;
            walk_scroll_reg <= 1'b0;
            walk_blank_reg  <= 1'b0;
            walk_idx_reg    <= '0;
            wr_pend_reg     <= 1'b0;
            wr_idx_reg      <= '0;
        end
        else
        begin
            wr_pend_reg <= walk_act_reg;
            wr_idx_reg  <= walk_idx_reg;
            if (walk_act_reg)
            begin
                walk_idx_reg <= walk_idx_reg + AW'(1);
                if (CW'(walk_idx_reg) == CW'(CELLS - 1))
                begin
                    walk_act_reg <= 1'b0;
                end
            end
            else if (cmd.walk_scroll || cmd.walk_blank)
            begin
                walk_act_reg    <= 1'b1;
                walk_scroll_reg <= cmd.walk_scroll;
                walk_blank_reg  <= cmd.walk_blank;
                walk_idx_reg    <= '0;
            end
        end
    end

    // Hold configuration and cursor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            def_attr_reg <= DEF_ATTR_RESET;
            cur_cell_reg <= '0;
            cur_row_reg  <= '0;
            cur_col_reg  <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                def_attr_reg <= cfg_write_data;
            end
            cur_cell_reg <= cur_cell_next;
            cur_row_reg  <= cur_row_next;
            cur_col_reg  <= cur_col_next;
        end
    end

    // Load the result word
    assign cur_wide = 16'(cur_cell_next);
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            status          <= (sts.is_put || sts.is_read) && sts.oor;
            cursor_position <= cur_wide[10:0];
            if (sts.is_read && !sts.oor)
            begin
                cell_char <= rdata_reg[7:0];
                cell_attr <= rdata_reg[15:8];
            end
            else
            begin
                cell_char <= 8'd0;
                cell_attr <= 8'd0;
            end
        end
    end

endmodule

### rtl/text_console_writer.sv
// Top level of the text console writer: character cell buffer with cursor.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
//
//  channel  handshake                  word
//  in       in_valid / in_ready        action, char_code, attribute, column, line
//  out      out_valid / out_ready      status, cursor_position, cell_char, cell_attr
//  cfg      cfg_write_en               cfg_write_data (default attribute)
//
// A put without scroll, an out-of-range put or read, or an unused action ends
// in the execute state; a read adds a wait state for the registered read port
// of the cell buffer. Clear and a put that scrolls walk the whole buffer, one
// cell a cycle. After reset a pass that zero-fills the buffer runs, and
// in_ready rises in the cycle after it ends. A stalled result holds the next
// word in its last step until the result register frees.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        action,
    input  logic [7:0]        char_code,
    input  logic [7:0]        attribute,
    input  logic signed [8:0] column,
    input  logic signed [8:0] line,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              status,
    output logic [10:0]       cursor_position,
    output logic [7:0]        cell_char,
    output logic [7:0]        cell_attr,
    input  logic              cfg_write_en,
    input  logic [7:0]        cfg_write_data
);

    tcw_cmd_t cmd;
    tcw_sts_t sts;

    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .action          (action),
        .char_code       (char_code),
        .attribute       (attribute),
        .column          (column),
        .line            (line),
        .status          (status),
        .cursor_position (cursor_position),
        .cell_char       (cell_char),
        .cell_attr       (cell_attr)
    );

`ifndef SYNTHESIS
    // No word is taken while a buffer pass runs
    a_no_accept_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !sts.walk_busy)
        else $error("word accepted during buffer pass");

    // One word at a time
    a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second word taken before the first finished");

    // Never overwrite a result the sink has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid || out_ready))
        else $error("pending result overwritten");
`endif

endmodule
